@@ rtl/assert_macros.svh @@
// Assertion macros shared by the positional list engine RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("assertion failed: invariant violated");

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication violated");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/plist_pkg.sv @@
// Package with the sizes, codes and interface types of the positional list engine.
`default_nettype none

package plist_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;

	localparam int CMD_W   = 3;
	localparam int VAL_W   = 32;
	localparam int POS_W   = 5;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;
	localparam int ELEM_W  = 32;
	localparam int OUT_USER_W = STAT_W + 1;

	localparam int IN_TDATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((COUNT_W + ELEM_W + 7) / 8) * 8;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_FIRST = 3'd0,
		CMD_INS_LAST  = 3'd1,
		CMD_INS_AT    = 3'd2,
		CMD_DEL_FIRST = 3'd3,
		CMD_DEL_LAST  = 3'd4,
		CMD_DEL_AT    = 3'd5,
		CMD_READOUT   = 3'd6
	} cmd_code_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE    = 2'd0,
		STAT_IGNORED = 2'd1,
		STAT_FULL    = 2'd2
	} stat_code_t;

	typedef struct packed {
		logic take;
		logic step;
	} plist_cmd_t;

	typedef struct packed {
		logic out_free;
		logic rd_more;
		logic rd_last;
	} plist_sts_t;

endpackage

`default_nettype wire

@@ rtl/plist_ctrl.sv @@
// Controller state machine of the positional list engine.
`default_nettype none
`include "assert_macros.svh"

module plist_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	input  plist_pkg::plist_sts_t  sts,
	output logic                   in_ready,
	output plist_pkg::plist_cmd_t  cmd
);
	import plist_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = sts.out_free;
				cmd.take = in_valid && sts.out_free;
				if (cmd.take && sts.rd_more) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.step = sts.out_free;
				if (sts.out_free && sts.rd_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_ALWAYS(a_take_step_excl, clk, arst_n, !(cmd.take && cmd.step))
	`ASSERT_IMPLIES(a_read_blocks_in, clk, arst_n, state_q == ST_READ, !in_ready)
	`ASSERT_NEXT(a_step_to_read, clk, arst_n, cmd.take && sts.rd_more, state_q == ST_READ)

endmodule

`default_nettype wire

@@ rtl/plist_dp.sv @@
// Datapath of the positional list engine: shifting cells, count and result register.
`default_nettype none
`include "assert_macros.svh"

module plist_dp (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  plist_pkg::plist_cmd_t               cmd,
	output plist_pkg::plist_sts_t               sts,
	input  wire [plist_pkg::IN_TDATA_W-1:0]     in_tdata,
	input  wire [plist_pkg::CMD_W-1:0]          in_tuser,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [plist_pkg::OUT_TDATA_W-1:0]   out_tdata,
	output logic [plist_pkg::OUT_USER_W-1:0]    out_tuser,
	output logic                                out_tlast
);
	import plist_pkg::*;

	localparam int PAD_W = OUT_TDATA_W - COUNT_W - ELEM_W;

	logic [DATA_WIDTH-1:0] entries_q [CAPACITY];
	logic [DATA_WIDTH-1:0] entries_d [CAPACITY];
	logic [CNT_W-1:0]      held_q;
	logic [CNT_W-1:0]      held_d;
	logic [IDX_W-1:0]      rd_idx_q;
	logic                  out_valid_q;
	stat_code_t            status_q;
	logic [COUNT_W-1:0]    count_q;
	logic [ELEM_W-1:0]     element_q;
	logic                  has_q;
	logic                  last_q;

	cmd_code_t             code;
	logic [POS_W-1:0]      pos;
	logic [DATA_WIDTH-1:0] val;
	logic [CMP_W-1:0]      pos_x;
	logic [CMP_W-1:0]      held_x;
	logic [CMP_W-1:0]      ins_idx;
	logic [CMP_W-1:0]      del_idx;
	logic                  is_ins;
	logic                  is_del;
	logic                  is_rd;
	logic                  pos_ok;
	logic                  full;
	stat_code_t            stat_d;

	always_comb begin
		code    = cmd_code_t'(in_tuser);
		pos     = in_tdata[VAL_W +: POS_W];
		val     = DATA_WIDTH'(in_tdata[VAL_W-1:0]);
		pos_x   = CMP_W'(pos);
		held_x  = CMP_W'(held_q);
		is_ins  = 1'b0;
		is_del  = 1'b0;
		is_rd   = 1'b0;
		pos_ok  = 1'b0;
		ins_idx = '0;
		del_idx = '0;
		unique case (code)
			CMD_INS_FIRST: begin
				is_ins = 1'b1;
				pos_ok = 1'b1;
			end
			CMD_INS_LAST: begin
				is_ins  = 1'b1;
				pos_ok  = 1'b1;
				ins_idx = held_x;
			end
			CMD_INS_AT: begin
				is_ins  = 1'b1;
				pos_ok  = (pos_x != '0) && (pos_x <= held_x + CMP_W'(1));
				ins_idx = pos_x - CMP_W'(1);
			end
			CMD_DEL_FIRST: begin
				is_del = 1'b1;
				pos_ok = (held_x != '0);
			end
			CMD_DEL_LAST: begin
				is_del  = 1'b1;
				pos_ok  = (held_x != '0);
				del_idx = held_x - CMP_W'(1);
			end
			CMD_DEL_AT: begin
				is_del  = 1'b1;
				pos_ok  = (pos_x != '0) && (pos_x <= held_x);
				del_idx = pos_x - CMP_W'(1);
			end
			CMD_READOUT: begin
				is_rd = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		full      = (held_q == CNT_W'(CAPACITY));
		stat_d    = STAT_IGNORED;
		held_d    = held_q;
		entries_d = entries_q;
		if (is_rd) begin
			stat_d = STAT_DONE;
		end else if (is_ins && pos_ok) begin
			if (full) begin
				stat_d = STAT_FULL;
			end else begin
				stat_d = STAT_DONE;
				held_d = held_q + CNT_W'(1);
				for (int i = 0; i < CAPACITY; i++) begin
					if (CMP_W'(i) == ins_idx) begin
						entries_d[i] = val;
					end else if (i > 0 && CMP_W'(i) > ins_idx) begin
						entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
					end
				end
			end
		end else if (is_del && pos_ok) begin
			stat_d = STAT_DONE;
			held_d = held_q - CNT_W'(1);
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (CMP_W'(i) >= del_idx) begin
					entries_d[i] = entries_q[i + 1];
				end
			end
		end
	end

	always_comb begin
		sts.out_free = !out_valid_q || out_ready;
		sts.rd_more  = is_rd && (held_q > CNT_W'(1));
		sts.rd_last  = (CNT_W'(rd_idx_q) + CNT_W'(1) == held_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			entries_q <= entries_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				held_q   <= held_d;
				rd_idx_q <= IDX_W'(1);
			end else if (cmd.step) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			if (cmd.take || cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			status_q <= stat_d;
			count_q  <= COUNT_W'(held_d);
			if (is_rd && held_q != '0) begin
				element_q <= ELEM_W'(entries_q[0]);
				has_q     <= 1'b1;
				last_q    <= (held_q == CNT_W'(1));
			end else begin
				element_q <= '0;
				has_q     <= 1'b0;
				last_q    <= 1'b1;
			end
		end else if (cmd.step) begin
			status_q  <= STAT_DONE;
			count_q   <= COUNT_W'(held_q);
			element_q <= ELEM_W'(entries_q[rd_idx_q]);
			has_q     <= 1'b1;
			last_q    <= sts.rd_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_tdata = {{PAD_W{1'b0}}, element_q, count_q};
	assign out_tuser = {has_q, status_q};
	assign out_tlast = last_q;

	`ASSERT_ALWAYS(a_held_bound, clk, arst_n, held_q <= CNT_W'(CAPACITY))
	`ASSERT_NEXT(a_held_only_on_take, clk, arst_n, !cmd.take, $stable(held_q))
	`ASSERT_IMPLIES(a_step_in_list, clk, arst_n, cmd.step, CNT_W'(rd_idx_q) < held_q)

endmodule

`default_nettype wire

@@ rtl/positional_list_engine.sv @@
// Top level of the positional list engine: a bounded ordered list driven by commands.
//
// Commands enter on the s_axis channel: tuser carries the command code, tdata the
// value to insert and the one-based position. Results leave on the m_axis channel:
// tdata carries the count after the command and the element, tuser the status and
// the has-element flag, and tlast marks the final result of a command.
// Every result sits in an output register; the first result of a command appears
// in the cycle after the command is accepted. Insert, delete and unknown commands
// give one result each; the block takes one such command per cycle while the receiver
// keeps up. A read-out of n elements gives n results (one result for an empty list);
// the element index counter steps once per cycle while the receiver keeps up, and no
// new command is taken until the last element is loaded into the output register.
// Reset empties the list and drops any pending result. When the receiver stalls,
// the output register holds its result and s_axis_tready falls until it is taken.
`default_nettype none

module positional_list_engine (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// Fields from bit 0: value, position, zero padding.
	input  wire [plist_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// Fields from bit 0: command.
	input  wire [plist_pkg::CMD_W-1:0]          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// Fields from bit 0: count, element, zero padding.
	output logic [plist_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// Fields from bit 0: status, has_element.
	output logic [plist_pkg::OUT_USER_W-1:0]    m_axis_tuser,
	output logic                                m_axis_tlast
);
	import plist_pkg::*;

	plist_cmd_t cmd;
	plist_sts_t sts;

	plist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.sts      (sts),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	plist_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_tdata  (s_axis_tdata),
		.in_tuser  (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_tdata (m_axis_tdata),
		.out_tuser (m_axis_tuser),
		.out_tlast (m_axis_tlast)
	);

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the positional list engine: directed table, then random command phases.
`timescale 1ns / 100ps

module testbench;

	import plist_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd7;
	localparam int MAX_GAP         = 18;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int ITEMS_PER_PHASE = 24;
	localparam int PHASES          = 6;

	typedef enum {PH_GROW, PH_MIXED, PH_SHRINK} phase_kind_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] count;
		logic [ELEM_W-1:0]  element;
		logic               has_element;
		logic               last;
	} list_result_t;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [VAL_W-1:0] val;
		logic [POS_W-1:0] pos;
		int               reps;
		bit               typed;
		list_result_t     res;
	} plan_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [CMD_W-1:0]       s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0]  m_axis_tuser;
	logic                   m_axis_tlast;

	logic [ELEM_W-1:0] list_mem [CAPACITY];
	int                list_len = 0;
	list_result_t      results_due [$];
	plan_row_t         plan [$];

	bit           offer_typed = 1'b0;
	list_result_t offer_result = '0;
	bit           tx_rush = 1'b0;
	bit           rx_rush = 1'b0;
	logic         hold_req = 1'b0;
	bit           hold_done = 1'b0;

	int error_count = 0;
	int quiet_cycles = 0;
	int commands_seen = 0;
	int results_seen = 0;
	int full_readouts = 0;
	int full_hits = 0;
	int ignored_hits = 0;

	positional_list_engine u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void push_result(input stat_code_t st, input logic [ELEM_W-1:0] elem,
			input logic has, input logic fin);
		list_result_t r;
		r = '{status: st, count: COUNT_W'(list_len), element: elem, has_element: has, last: fin};
		results_due.push_back(r);
	endfunction

	function automatic stat_code_t list_insert(input int idx, input logic [ELEM_W-1:0] v);
		int i;
		if (list_len >= CAPACITY)
			return STAT_FULL;
		for (i = list_len; i > idx; i--)
			list_mem[i] = list_mem[i - 1];
		list_mem[idx] = v;
		list_len++;
		return STAT_DONE;
	endfunction

	function automatic stat_code_t list_remove(input int idx);
		int i;
		for (i = idx; i + 1 < list_len; i++)
			list_mem[i] = list_mem[i + 1];
		list_len--;
		return STAT_DONE;
	endfunction

	function automatic void apply_command(input logic [CMD_W-1:0] cmd,
			input logic [VAL_W-1:0] val, input logic [POS_W-1:0] pos);
		stat_code_t st;
		int i;
		st = STAT_IGNORED;
		case (cmd)
			CMD_INS_FIRST: st = list_insert(0, val);
			CMD_INS_LAST:  st = list_insert(list_len, val);
			CMD_INS_AT:    if (pos >= 1 && pos <= list_len + 1) st = list_insert(pos - 1, val);
			CMD_DEL_FIRST: if (list_len > 0) st = list_remove(0);
			CMD_DEL_LAST:  if (list_len > 0) st = list_remove(list_len - 1);
			CMD_DEL_AT:    if (pos >= 1 && pos <= list_len) st = list_remove(pos - 1);
			CMD_READOUT: begin
				if (list_len == 0)
					push_result(STAT_DONE, '0, 1'b0, 1'b1);
				if (list_len == CAPACITY)
					full_readouts++;
				for (i = 0; i < list_len; i++)
					push_result(STAT_DONE, list_mem[i], 1'b1, i == list_len - 1);
			end
			default: ;
		endcase
		if (cmd != CMD_READOUT)
			push_result(st, '0, 1'b0, 1'b1);
	endfunction

	function automatic void check_field(input string name, input logic [ELEM_W-1:0] want,
			input logic [ELEM_W-1:0] got);
		if (want !== got) begin
			$display("%0d ns: %s expected %0h, got %0h", $time, name, want, got);
			error_count++;
		end
	endfunction

	function automatic int draw_gap(inout bit rush);
		if ($urandom_range(0, 19) == 0)
			rush = !rush;
		return rush ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic void add_row(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos, input int reps, input bit typed,
			input stat_code_t st, input int cnt);
		plan_row_t row;
		row.cmd = cmd;
		row.val = val;
		row.pos = pos;
		row.reps = reps;
		row.typed = typed;
		row.res = '{status: st, count: COUNT_W'(cnt), element: '0, has_element: 1'b0, last: 1'b1};
		plan.push_back(row);
	endfunction

	// Mostly in-range positions for the current length, with some raw noise items mixed in.
	function automatic void pick_command(input phase_kind_t kind, input int len,
			output logic [CMD_W-1:0] cmd, output logic [VAL_W-1:0] val,
			output logic [POS_W-1:0] pos);
		int r;
		int ins_share;
		r = $urandom_range(0, 99);
		val = ($urandom_range(0, 15) == 0) ? '1 : $urandom;
		pos = POS_W'($urandom_range(0, 31));
		ins_share = (kind == PH_GROW) ? 75 : (kind == PH_SHRINK) ? 25 : 50;
		if (r < 10) begin
			cmd = CMD_W'($urandom_range(0, 7));
		end else if (r < 22) begin
			cmd = CMD_READOUT;
		end else if ($urandom_range(0, 99) < ins_share) begin
			case ($urandom_range(0, 2))
				0: cmd = CMD_INS_FIRST;
				1: cmd = CMD_INS_LAST;
				default: cmd = CMD_INS_AT;
			endcase
			if (cmd == CMD_INS_AT)
				pos = POS_W'($urandom_range(1, len + 1));
		end else begin
			case ($urandom_range(0, 2))
				0: cmd = CMD_DEL_FIRST;
				1: cmd = CMD_DEL_LAST;
				default: cmd = CMD_DEL_AT;
			endcase
			if (cmd == CMD_DEL_AT)
				pos = (len == 0) ? POS_W'(1) : POS_W'($urandom_range(1, len));
		end
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos, input bit typed, input list_result_t typed_res);
		int gap;
		logic [IN_TDATA_W-1:0] word;
		gap = draw_gap(tx_rush);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word = '0;
		word[VAL_W-1:0] = val;
		word[VAL_W +: POS_W] = pos;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= cmd;
		offer_typed <= typed;
		offer_result <= typed_res;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
	endtask

	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (results_due.size() != 0);
	endtask

	initial begin : sender
		plan_row_t row;
		phase_kind_t kinds [PHASES];
		logic [CMD_W-1:0] cmd;
		logic [VAL_W-1:0] val;
		logic [POS_W-1:0] pos;
		int r;
		int k;
		int p;
		kinds = '{PH_GROW, PH_MIXED, PH_SHRINK, PH_GROW, PH_MIXED, PH_SHRINK};

		add_row(CMD_DEL_FIRST, 32'h0, 5'd0, 1, 1'b1, STAT_IGNORED, 0);
		add_row(CMD_DEL_LAST, 32'h0, 5'd0, 1, 1'b1, STAT_IGNORED, 0);
		add_row(CMD_DEL_AT, 32'h0, 5'd1, 1, 1'b1, STAT_IGNORED, 0);
		add_row(CMD_READOUT, 32'h0, 5'd0, 1, 1'b1, STAT_DONE, 0);
		add_row(CMD_INS_AT, 32'h5, 5'd0, 1, 1'b1, STAT_IGNORED, 0);
		add_row(CMD_INS_AT, 32'h6, 5'd2, 1, 1'b1, STAT_IGNORED, 0);
		add_row(CMD_INS_FIRST, 32'hFFFF_FFFF, 5'd0, 1, 1'b1, STAT_DONE, 1);
		add_row(CMD_INS_LAST, 32'h0, 5'd31, 1, 1'b1, STAT_DONE, 2);
		add_row(CMD_INS_AT, 32'hA5A5_A5A5, 5'd3, 1, 1'b1, STAT_DONE, 3);
		add_row(CMD_INS_AT, 32'h5A5A_5A5A, 5'd1, 1, 1'b1, STAT_DONE, 4);
		add_row(CMD_READOUT, 32'h0, 5'd0, 1, 1'b0, STAT_DONE, 0);
		add_row(CMD_DEL_AT, 32'h0, 5'd0, 1, 1'b1, STAT_IGNORED, 4);
		add_row(CMD_DEL_AT, 32'h0, 5'd5, 1, 1'b1, STAT_IGNORED, 4);
		add_row(CMD_DEL_AT, 32'h0, 5'd31, 1, 1'b1, STAT_IGNORED, 4);
		add_row(CMD_UNKNOWN, 32'hFFFF_FFFF, 5'd31, 1, 1'b1, STAT_IGNORED, 4);
		add_row(CMD_DEL_AT, 32'h0, 5'd2, 1, 1'b1, STAT_DONE, 3);
		add_row(CMD_INS_AT, 32'h7, 5'd31, 1, 1'b1, STAT_IGNORED, 3);
		add_row(CMD_INS_LAST, 32'h8000_0000, 5'd0, 13, 1'b0, STAT_DONE, 0);
		add_row(CMD_INS_FIRST, 32'h1, 5'd0, 1, 1'b1, STAT_FULL, 16);
		add_row(CMD_INS_AT, 32'h2, 5'd17, 1, 1'b1, STAT_FULL, 16);
		add_row(CMD_INS_AT, 32'h3, 5'd18, 1, 1'b1, STAT_IGNORED, 16);
		add_row(CMD_INS_LAST, 32'h4, 5'd0, 1, 1'b1, STAT_FULL, 16);
		add_row(CMD_READOUT, 32'h0, 5'd0, 1, 1'b0, STAT_DONE, 0);
		add_row(CMD_DEL_AT, 32'h0, 5'd16, 1, 1'b1, STAT_DONE, 15);
		add_row(CMD_DEL_LAST, 32'h0, 5'd0, 1, 1'b1, STAT_DONE, 14);
		add_row(CMD_DEL_FIRST, 32'h0, 5'd0, 1, 1'b1, STAT_DONE, 13);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < plan.size(); r++) begin
			row = plan[r];
			for (k = 0; k < row.reps; k++)
				send_item(row.cmd, row.val + VAL_W'(k), row.pos, row.typed, row.res);
		end
		wait_for_results();

		for (p = 0; p < PHASES; p++) begin
			if (p == 1)
				hold_req <= 1'b1;
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				pick_command(kinds[p], list_len, cmd, val, pos);
				send_item(cmd, val, pos, 1'b0, '0);
			end
			wait_for_results();
		end

		repeat (8) @(posedge clk);
		$display("summary: %0d commands and %0d results checked, %0d read-outs of a full list.",
			commands_seen, results_seen, full_readouts);
		$display("summary: %0d results reported full and %0d reported ignored.",
			full_hits, ignored_hits);
		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	initial begin : receiver
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				gap = HOLD_CYCLES;
				hold_done = 1'b1;
			end else begin
				gap = draw_gap(rx_rush);
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(negedge clk); while (!m_axis_tvalid);
			@(posedge clk);
		end
	end

	// Handshakes are judged at the falling edge, where everything for the next rising edge is settled.
	always @(negedge clk) begin : watch
		list_result_t got;
		list_result_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				results_seen++;
				got = '{status: m_axis_tuser[STAT_W-1:0], count: m_axis_tdata[COUNT_W-1:0],
					element: m_axis_tdata[COUNT_W +: ELEM_W],
					has_element: m_axis_tuser[STAT_W], last: m_axis_tlast};
				if (results_due.size() == 0) begin
					$display("%0d ns: unexpected result status %0d count %0d element %0h",
						$time, got.status, got.count, got.element);
					error_count++;
				end else begin
					want = results_due.pop_front();
					check_field("status", ELEM_W'(want.status), ELEM_W'(got.status));
					check_field("count", ELEM_W'(want.count), ELEM_W'(got.count));
					check_field("element", want.element, got.element);
					check_field("has_element", ELEM_W'(want.has_element), ELEM_W'(got.has_element));
					check_field("last", ELEM_W'(want.last), ELEM_W'(got.last));
					if (want.status == STAT_FULL)
						full_hits++;
					if (want.status == STAT_IGNORED)
						ignored_hits++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				moved = 1'b1;
				commands_seen++;
				apply_command(s_axis_tuser, s_axis_tdata[VAL_W-1:0], s_axis_tdata[VAL_W +: POS_W]);
				if (offer_typed)
					results_due[results_due.size() - 1] = offer_result;
			end
			if (moved)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0d ns: no item moved for %0d cycles", $time, quiet_cycles);
				$display("testbench: errors");
				$finish;
			end
		end
	end

endmodule
